// ===== hdl/dmic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dmic_pkg;

   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned DATA_W     = 64;
   localparam int unsigned SRC_W      = 4;
   localparam int unsigned WORD_SHIFT = 3;
   localparam int unsigned WORD_W     = ADDR_W - WORD_SHIFT;

   localparam logic OP_FETCH = 1'b0;
   localparam logic OP_FILL  = 1'b1;

   typedef enum logic [1:0] {
      KIND_HIT  = 2'd0,
      KIND_MISS = 2'd1,
      KIND_FILL = 2'd2
   } dmic_kind_type;

   typedef struct packed {
      logic                       opcode;
      logic [ADDR_W-1:0]          address;
      logic signed [DATA_W-1:0]   payload;
      logic [SRC_W-1:0]           source;
   } dmic_item_type;

endpackage

`default_nettype wire

// ===== hdl/dmic_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dmic_front #(
   parameter int unsigned NUM_LINES = 128
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   output logic                                   full,
   input  wire dmic_pkg::dmic_item_type           item,
   output logic                                   q_push,
   input  wire logic                              q_full,
   output dmic_pkg::dmic_item_type                q_item,
   output logic [$clog2(NUM_LINES)-1:0]           q_idx
);

   localparam int unsigned IDX_W = $clog2(NUM_LINES);
   localparam int unsigned WW    = dmic_pkg::WORD_W;
   localparam int unsigned SH    = WW + IDX_W;
   localparam int unsigned MW    = WW + 1;
   localparam int unsigned PW    = WW + MW;
   // Reciprocal scaled so that the quotient is exact for every word number.
   localparam logic [63:0] MAGIC   = ((64'd1 << SH) + 64'(NUM_LINES) - 64'd1) / 64'(NUM_LINES);
   localparam logic [MW-1:0] MAGIC_W = MAGIC[MW-1:0];

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_MOD,
      F_READY
   } state_type;

   state_type                 state_ff, state_in;
   dmic_pkg::dmic_item_type   item_ff;
   logic [PW-1:0]             prod_ff, prod_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [WW-1:0]             word_num;
   logic [WW-1:0]             quot;
   logic [WW-1:0]             quot_n;
   logic [WW-1:0]             rem;

   assign word_num = item_ff.address[dmic_pkg::ADDR_W-1:dmic_pkg::WORD_SHIFT];
   assign prod_in  = PW'(word_num) * PW'(MAGIC_W);
   assign quot     = WW'(prod_ff >> SH);
   assign quot_n   = WW'(quot * WW'(NUM_LINES));
   assign rem      = word_num - quot_n;
   assign idx_in   = rem[IDX_W-1:0];

   assign full   = (state_ff != F_IDLE);
   assign q_push = (state_ff == F_READY) && !q_full;
   assign q_item = item_ff;
   assign q_idx  = idx_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:  if (push) state_in = F_MUL;
         F_MUL:   state_in = F_MOD;
         F_MOD:   state_in = F_READY;
         F_READY: if (!q_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (state_ff == F_IDLE && push) begin
         item_ff <= item;
      end
      if (state_ff == F_MUL) begin
         prod_ff <= prod_in;
      end
      if (state_ff == F_MOD) begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/dmic_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dmic_queue #(
   parameter int unsigned IDX_W = 7
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   output logic                           full,
   input  wire dmic_pkg::dmic_item_type   push_item,
   input  wire logic [IDX_W-1:0]          push_idx,
   input  wire logic                      pop,
   output logic                           empty,
   output dmic_pkg::dmic_item_type        pop_item,
   output logic [IDX_W-1:0]               pop_idx
);

   dmic_pkg::dmic_item_type   item_ff [2];
   logic [IDX_W-1:0]          idx_ff  [2];
   logic                      wr_ptr_ff, rd_ptr_ff;
   logic [1:0]                count_ff, count_in;
   logic                      do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = item_ff[rd_ptr_ff];
   assign pop_idx  = idx_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 2'd1;
      if (do_pop && !do_push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
      end
      if (do_push) begin
         item_ff[wr_ptr_ff] <= push_item;
         idx_ff[wr_ptr_ff]  <= push_idx;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/dmic_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dmic_back #(
   parameter int unsigned NUM_LINES = 128
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_empty,
   output logic                                   q_pop,
   input  wire dmic_pkg::dmic_item_type           q_item,
   input  wire logic [$clog2(NUM_LINES)-1:0]      q_idx,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [1:0]                             rsp_kind,
   output logic [dmic_pkg::ADDR_W-1:0]            rsp_out_address,
   output logic signed [dmic_pkg::DATA_W-1:0]     rsp_out_payload,
   output logic [dmic_pkg::SRC_W-1:0]             rsp_out_source
);

   typedef enum logic {
      B_IDLE,
      B_LOOKUP
   } state_type;

   state_type                          state_ff;
   logic [NUM_LINES-1:0]               valid_ff;
   logic [dmic_pkg::ADDR_W-1:0]        tag_mem  [NUM_LINES];
   logic [dmic_pkg::DATA_W-1:0]        data_mem [NUM_LINES];
   logic [dmic_pkg::ADDR_W-1:0]        rd_tag_ff;
   logic [dmic_pkg::DATA_W-1:0]        rd_data_ff;
   logic                               look_valid_ff;
   dmic_pkg::dmic_item_type            cur_ff;

   logic                               out_valid_ff;
   dmic_pkg::dmic_kind_type            kind_ff;
   logic [dmic_pkg::ADDR_W-1:0]        addr_ff;
   logic signed [dmic_pkg::DATA_W-1:0] payload_ff;
   logic [dmic_pkg::SRC_W-1:0]         source_ff;

   logic out_free, is_fill, rd_en, wr_en, look_done, hit;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign is_fill   = (q_item.opcode == dmic_pkg::OP_FILL);
   // A fill delivers at once, so it needs the result slot; a fetch waits in lookup.
   assign q_pop     = (state_ff == B_IDLE) && !q_empty && (!is_fill || out_free);
   assign rd_en     = q_pop && !is_fill;
   assign wr_en     = q_pop && is_fill;
   assign look_done = (state_ff == B_LOOKUP) && out_free;
   assign hit       = look_valid_ff && (rd_tag_ff == cur_ff.address);

   assign rsp_empty       = !out_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_out_address = addr_ff;
   assign rsp_out_payload = payload_ff;
   assign rsp_out_source  = source_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[q_idx]  <= q_item.address;
         data_mem[q_idx] <= q_item.payload;
      end
      if (rd_en) begin
         rd_tag_ff  <= tag_mem[q_idx];
         rd_data_ff <= data_mem[q_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            B_IDLE:   if (rd_en) state_ff <= B_LOOKUP;
            B_LOOKUP: if (look_done) state_ff <= B_IDLE;
            default:  state_ff <= B_IDLE;
         endcase
         if (wr_en) valid_ff[q_idx] <= 1'b1;
         if (wr_en || look_done) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (rd_en) begin
         cur_ff        <= q_item;
         look_valid_ff <= valid_ff[q_idx];
      end
      if (wr_en) begin
         kind_ff    <= dmic_pkg::KIND_FILL;
         addr_ff    <= q_item.address;
         payload_ff <= q_item.payload;
         source_ff  <= q_item.source;
      end else if (look_done) begin
         kind_ff    <= hit ? dmic_pkg::KIND_HIT : dmic_pkg::KIND_MISS;
         addr_ff    <= cur_ff.address;
         payload_ff <= hit ? rd_data_ff : '0;
         source_ff  <= cur_ff.source;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/direct_mapped_insn_cache_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Direct-mapped instruction cache, one 64-bit word per line and NUM_LINES lines
// (a power of two or not), tagged by the full 32-bit address. A fetch returns a
// hit with the stored word or a miss with zero payload; a fill writes its line,
// marks it valid and comes back as a fill response. Exactly one result per item,
// in order. The front stage holds an accepted item while it reduces the word
// address to a line index with two registered multiplies and takes the next one
// in the cycle after it hands off; a two-entry queue then decouples it from the
// back end, which delivers a fill as it pops it and a fetch from its lookup state
// after a registered tag and data read. The front stage takes no new item until
// it has handed off the last, so it sets the sustained rate. Valid bits are flops
// cleared by reset, so no clearing pass is needed before items are accepted.
module direct_mapped_insn_cache_core #(
   parameter int unsigned NUM_LINES = 128
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire logic                              req_opcode,
   input  wire logic [31:0]                       req_address,
   input  wire logic signed [63:0]                req_payload,
   input  wire logic [3:0]                        req_source,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [1:0]                             rsp_kind,
   output logic [31:0]                            rsp_out_address,
   output logic signed [63:0]                     rsp_out_payload,
   output logic [3:0]                             rsp_out_source
);

   localparam int unsigned IDX_W = $clog2(NUM_LINES);

   dmic_pkg::dmic_item_type   req_item;
   dmic_pkg::dmic_item_type   fq_item, qb_item;
   logic [IDX_W-1:0]          fq_idx, qb_idx;
   logic                      fq_push, fq_full, qb_pop, qb_empty;

   assign req_item.opcode  = req_opcode;
   assign req_item.address = req_address;
   assign req_item.payload = req_payload;
   assign req_item.source  = req_source;

   dmic_front #(.NUM_LINES(NUM_LINES)) u_front (
      .clock  (clock),
      .reset  (reset),
      .push   (req_push),
      .full   (req_full),
      .item   (req_item),
      .q_push (fq_push),
      .q_full (fq_full),
      .q_item (fq_item),
      .q_idx  (fq_idx)
   );

   dmic_queue #(.IDX_W(IDX_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .full      (fq_full),
      .push_item (fq_item),
      .push_idx  (fq_idx),
      .pop       (qb_pop),
      .empty     (qb_empty),
      .pop_item  (qb_item),
      .pop_idx   (qb_idx)
   );

   dmic_back #(.NUM_LINES(NUM_LINES)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (qb_empty),
      .q_pop           (qb_pop),
      .q_item          (qb_item),
      .q_idx           (qb_idx),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kind        (rsp_kind),
      .rsp_out_address (rsp_out_address),
      .rsp_out_payload (rsp_out_payload),
      .rsp_out_source  (rsp_out_source)
   );

endmodule

`default_nettype wire

// ===== hdl/dmic_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dmic_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_push,
   input wire logic               req_full,
   input wire logic               rsp_empty,
   input wire logic               rsp_pop,
   input wire logic [1:0]         rsp_kind,
   input wire logic [31:0]        rsp_out_address,
   input wire logic signed [63:0] rsp_out_payload
);

   // Nothing waits on the result side straight after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   // A miss never carries data.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == dmic_pkg::KIND_MISS) |-> rsp_out_payload == 64'sd0)
      else $error("miss with non-zero payload");

   // The front stage reports full once it has accepted a beat.
   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> req_full)
      else $error("front took a second beat too early");

   // A result not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_address)
                                    && $stable(rsp_kind)))
      else $error("stalled result changed");

endmodule

bind direct_mapped_insn_cache_core dmic_checker u_dmic_checker (
   .clock           (clock),
   .reset           (reset),
   .req_push        (req_push),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_kind        (rsp_kind),
   .rsp_out_address (rsp_out_address),
   .rsp_out_payload (rsp_out_payload)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned LINES      = 128;
   localparam int unsigned POOL_SIZE  = 48;
   localparam int unsigned RAND_ITEMS = 830;
   localparam int unsigned CYCLE_CAP  = 400000;
   localparam int unsigned DRAIN      = 24;

   typedef struct packed {
      dmic_pkg::dmic_kind_type              kind;
      logic [dmic_pkg::ADDR_W-1:0]          address;
      logic signed [dmic_pkg::DATA_W-1:0]   payload;
      logic [dmic_pkg::SRC_W-1:0]           source;
   } cache_rsp_type;

   class cache_mirror;
      logic [dmic_pkg::ADDR_W-1:0]        line_tag   [LINES];
      bit                                 line_valid [LINES];
      logic signed [dmic_pkg::DATA_W-1:0] line_data  [LINES];
      cache_rsp_type                      due_rsps[$];
      int unsigned                        failures;

      function new();
         for (int i = 0; i < LINES; i++) begin
            line_valid[i] = 1'b0;
         end
         failures = 0;
      endfunction

      // Work out the one response an accepted beat causes and queue it.
      function void take_req(dmic_pkg::dmic_item_type req);
         int unsigned   idx;
         cache_rsp_type rsp;
         idx         = (req.address >> dmic_pkg::WORD_SHIFT) % LINES;
         rsp.address = req.address;
         rsp.source  = req.source;
         if (req.opcode == dmic_pkg::OP_FETCH) begin
            if (line_valid[idx] && line_tag[idx] == req.address) begin
               rsp.kind    = dmic_pkg::KIND_HIT;
               rsp.payload = line_data[idx];
            end else begin
               rsp.kind    = dmic_pkg::KIND_MISS;
               rsp.payload = '0;
            end
         end else begin
            line_tag[idx]   = req.address;
            line_data[idx]  = req.payload;
            line_valid[idx] = 1'b1;
            rsp.kind        = dmic_pkg::KIND_FILL;
            rsp.payload     = req.payload;
         end
         due_rsps.push_back(rsp);
      endfunction

      function void match_rsp(logic [1:0] kind, logic [dmic_pkg::ADDR_W-1:0] address,
                              logic signed [dmic_pkg::DATA_W-1:0] payload,
                              logic [dmic_pkg::SRC_W-1:0] source);
         cache_rsp_type want;
         if (due_rsps.size() == 0) begin
            $error("unexpected response beat: kind %0d address %h", kind, address);
            failures++;
            return;
         end
         want = due_rsps.pop_front();
         if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            failures++;
         end
         if (address !== want.address) begin
            $error("out_address: expected %h, got %h", want.address, address);
            failures++;
         end
         if (payload !== want.payload) begin
            $error("out_payload: expected %h, got %h", want.payload, payload);
            failures++;
         end
         if (source !== want.source) begin
            $error("out_source: expected %h, got %h", want.source, source);
            failures++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_push = 1'b0;
   logic                     req_full;
   logic                     req_opcode = dmic_pkg::OP_FETCH;
   logic [31:0]              req_address = '0;
   logic signed [63:0]       req_payload = '0;
   logic [3:0]               req_source = '0;
   logic                     rsp_empty;
   logic                     rsp_pop = 1'b0;
   logic [1:0]               rsp_kind;
   logic [31:0]              rsp_out_address;
   logic signed [63:0]       rsp_out_payload;
   logic [3:0]               rsp_out_source;

   int unsigned                 send_idle_pct = 0;
   int unsigned                 recv_idle_pct = 0;
   int unsigned                 cycle_count = 0;
   logic [dmic_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];
   cache_mirror                 mirror;

   direct_mapped_insn_cache_core #(
      .NUM_LINES(LINES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_opcode(req_opcode),
      .req_address(req_address),
      .req_payload(req_payload),
      .req_source(req_source),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_kind(rsp_kind),
      .rsp_out_address(rsp_out_address),
      .rsp_out_payload(rsp_out_payload),
      .rsp_out_source(rsp_out_source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_CAP) begin
         $display("[direct_mapped_insn_cache_core] ERROR");
         $finish;
      end
   end

   // Hold the beat until it is taken; idle slots drop push for a cycle.
   task automatic push_beat(logic op, logic [31:0] address, logic signed [63:0] payload,
                            logic [3:0] source);
      dmic_pkg::dmic_item_type beat;
      bit                      taken;
      beat.opcode  = op;
      beat.address = address;
      beat.payload = payload;
      beat.source  = source;
      taken        = 1'b0;
      while (!taken) begin
         @(negedge clock);
         if ($urandom_range(0, 99) < send_idle_pct) begin
            req_push <= 1'b0;
         end else begin
            req_push    <= 1'b1;
            req_opcode  <= op;
            req_address <= address;
            req_payload <= payload;
            req_source  <= source;
            @(posedge clock);
            if (!req_full) begin
               mirror.take_req(beat);
               taken = 1'b1;
            end
         end
      end
   endtask

   task automatic push_random(int unsigned count);
      logic              op;
      logic [31:0]       address;
      for (int n = 0; n < count; n++) begin
         op      = ($urandom_range(0, 99) < 40) ? dmic_pkg::OP_FILL : dmic_pkg::OP_FETCH;
         address = ($urandom_range(0, 99) < 75) ? addr_pool[$urandom_range(0, POOL_SIZE-1)]
                                                : $urandom;
         push_beat(op, address, {$urandom, $urandom}, 4'($urandom_range(0, 15)));
      end
   endtask

   initial begin
      mirror = new();
      // Few lines, several tags per line: fills, hits and evictions all recur.
      for (int i = 0; i < POOL_SIZE; i++) begin
         addr_pool[i] = ($urandom & 32'hFFFF_FC00)
                        | ($urandom_range(0, 15) << dmic_pkg::WORD_SHIFT);
         if ($urandom_range(0, 7) == 0) begin
            addr_pool[i][2:0] = 3'($urandom_range(1, 7));
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         rsp_pop <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            mirror.match_rsp(rsp_kind, rsp_out_address, rsp_out_payload, rsp_out_source);
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty lines miss whatever the address, sentinel tag included
      push_beat(dmic_pkg::OP_FETCH, 32'h0000_0000, 64'sd0, 4'h0);
      push_beat(dmic_pkg::OP_FETCH, 32'd100000000, 64'sd0, 4'h3);
      push_beat(dmic_pkg::OP_FETCH, 32'hFFFF_FFFF, 64'sd0, 4'hF);
      push_beat(dmic_pkg::OP_FILL,  32'h0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF, 4'h1);
      push_beat(dmic_pkg::OP_FETCH, 32'h0000_0000, 64'sd0, 4'h2);
      // unaligned: same line, different tag
      push_beat(dmic_pkg::OP_FETCH, 32'h0000_0001, 64'sd0, 4'h4);
      // overwrite a valid line
      push_beat(dmic_pkg::OP_FILL,  32'h0000_0000, 64'sh8000_0000_0000_0000, 4'h5);
      push_beat(dmic_pkg::OP_FETCH, 32'h0000_0000, 64'sd0, 4'h6);
      push_beat(dmic_pkg::OP_FILL,  32'h0000_0400, -64'sd1, 4'h7);
      push_beat(dmic_pkg::OP_FETCH, 32'h0000_0000, 64'sd0, 4'h8);
      push_beat(dmic_pkg::OP_FETCH, 32'h0000_0400, 64'sd0, 4'h9);
      push_beat(dmic_pkg::OP_FILL,  32'd100000000, 64'sd0, 4'hF);
      push_beat(dmic_pkg::OP_FETCH, 32'd100000000, 64'sd0, 4'hA);
      push_beat(dmic_pkg::OP_FILL,  32'hFFFF_FFFF, 64'sh5555_5555_5555_5555, 4'hB);
      push_beat(dmic_pkg::OP_FETCH, 32'hFFFF_FFF8, 64'sd0, 4'hC);
      push_beat(dmic_pkg::OP_FETCH, 32'hFFFF_FFFF, 64'sd0, 4'hD);
      push_beat(dmic_pkg::OP_FILL,  32'h0000_0007, 64'shAAAA_AAAA_AAAA_AAAA, 4'hE);
      push_beat(dmic_pkg::OP_FETCH, 32'h0000_0007, 64'sd0, 4'h0);
      push_beat(dmic_pkg::OP_FETCH, 32'h0000_0000, 64'sd0, 4'h1);
      push_beat(dmic_pkg::OP_FILL,  32'hFFFF_FFF8, 64'sh0123_4567_89AB_CDEF, 4'h2);
      push_beat(dmic_pkg::OP_FETCH, 32'hFFFF_FFF8, 64'sd0, 4'h3);

      send_idle_pct = 28;
      recv_idle_pct = 84;
      push_random(RAND_ITEMS / 3);
      send_idle_pct = 84;
      recv_idle_pct = 28;
      push_random(RAND_ITEMS / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      push_random(RAND_ITEMS - 2 * (RAND_ITEMS / 3));

      @(negedge clock);
      req_push <= 1'b0;
      while (mirror.due_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (mirror.failures == 0 && mirror.due_rsps.size() == 0) begin
         $display("[direct_mapped_insn_cache_core] OK");
      end else begin
         $display("[direct_mapped_insn_cache_core] ERROR");
      end
      $finish;
   end

endmodule
